// ----- rtl/iphc_pkg.sv -----
`timescale 1ns / 1ps

package iphc_pkg;

	// smallest datagram that can hold a fixed header
	localparam int unsigned MIN_HEADER_BYTES = 20;

	// byte counter holds 0..65536, stops at the top
	localparam int unsigned CNT_W = 17;

	localparam logic [3:0]  IP_VERSION  = 4'd4;
	localparam logic [3:0]  MIN_IHL     = 4'd5;
	localparam logic [15:0] CSUM_GOOD   = 16'hffff;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TOO_SHORT    = 3'd1,
		ST_BAD_VERSION  = 3'd2,
		ST_HDR_SHORT    = 3'd3,
		ST_LEN_MISMATCH = 3'd4,
		ST_BAD_CSUM     = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_word_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  ihl_words;
		logic [7:0]  type_of_service;
		logic [15:0] total_length;
		logic [15:0] ident;
		logic        dont_fragment;
		logic        more_fragments;
		logic [12:0] frag_offset;
		logic [7:0]  time_to_live;
		logic [7:0]  protocol;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
	} hdr_word_t;

	// controls for the checksum accumulator
	typedef struct packed {
		logic adv;     // a byte leaves stage 1
		logic clr;     // end of datagram, start over
		logic take;    // byte lies inside the header
		logic odd;     // byte completes a 16-bit word
	} csum_ctl_t;

endpackage

// ----- rtl/iphc_if.sv -----
`timescale 1ns / 1ps

interface iphc_byte_if import iphc_pkg::*; ();
	logic       valid;
	logic       ready;
	byte_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iphc_hdr_if import iphc_pkg::*; ();
	logic      valid;
	logic      ready;
	hdr_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ipv4_header_parse_check.sv -----
`timescale 1ns / 1ps

// channel  dir  word         contents
// pkt      in   byte_word_t  one datagram byte, network order, last_byte on the final one
// res      out  hdr_word_t   decoded header fields and check status, one per datagram
//
// one byte is taken per cycle unless a final byte is stalled; a datagram's result follows its
// last byte through the input register, then the result register
// arst_n clears the byte counter, checksum and all captured fields
// a full result register stalls only a final byte; other bytes keep moving
// pkt.ready follows res.ready combinationally through stage 1

module ipv4_header_parse_check import iphc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	iphc_byte_if.sink       pkt,
	iphc_hdr_if.source      res
);

	// stage 1: registered input byte
	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;

	// per-datagram state
	logic [CNT_W-1:0] count_q;
	logic [7:0]       first_q;
	logic [7:0]       tos_q;
	logic [15:0]      length_q;
	logic [15:0]      ident_q;
	logic [15:0]      flags_q;
	logic [7:0]       ttl_q;
	logic [7:0]       proto_q;
	logic [31:0]      src_q;
	logic [31:0]      dst_q;

	// next values after this byte's capture
	logic [7:0]       first_nx;
	logic [7:0]       tos_nx;
	logic [15:0]      length_nx;
	logic [15:0]      ident_nx;
	logic [15:0]      flags_nx;
	logic [7:0]       ttl_nx;
	logic [7:0]       proto_nx;
	logic [31:0]      src_nx;
	logic [31:0]      dst_nx;

	logic [CNT_W-1:0] total;
	logic [5:0]       hdr_bytes;
	logic [15:0]      sum_nx;
	logic             advance;
	csum_ctl_t        csum_ctl;
	status_t          status;
	hdr_word_t        result;

	logic             out_valid_q;
	hdr_word_t        out_q;

	// a final byte waits while the result register is full
	assign advance   = valid_s1 && (!last_s1 || !out_valid_q || res.ready);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			data_s1 <= pkt.data.data_byte;
			last_s1 <= pkt.data.last_byte;
		end
	end

	// field capture by byte position
	always_comb begin
		first_nx  = first_q;
		tos_nx    = tos_q;
		length_nx = length_q;
		ident_nx  = ident_q;
		flags_nx  = flags_q;
		ttl_nx    = ttl_q;
		proto_nx  = proto_q;
		src_nx    = src_q;
		dst_nx    = dst_q;
		unique case (count_q)
			17'd0: first_nx = data_s1;
			17'd1: tos_nx   = data_s1;
			17'd2, 17'd3: length_nx = {length_q[7:0], data_s1};
			17'd4, 17'd5: ident_nx  = {ident_q[7:0], data_s1};
			17'd6, 17'd7: flags_nx  = {flags_q[7:0], data_s1};
			17'd8: ttl_nx   = data_s1;
			17'd9: proto_nx = data_s1;
			17'd12, 17'd13, 17'd14, 17'd15: src_nx = {src_q[23:0], data_s1};
			17'd16, 17'd17, 17'd18, 17'd19: dst_nx = {dst_q[23:0], data_s1};
			default: ;
		endcase
	end

	// header length in bytes, from the version/ihl byte as just captured
	assign hdr_bytes = {first_nx[3:0], 2'b00};

	// saturating byte count including this byte
	assign total = count_q[CNT_W-1] ? count_q : count_q + 1'b1;

	always_comb begin
		csum_ctl.adv  = advance;
		csum_ctl.clr  = last_s1;
		csum_ctl.take = count_q < {{(CNT_W-6){1'b0}}, hdr_bytes};
		csum_ctl.odd  = count_q[0];
	end

	iphc_csum u_csum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (csum_ctl),
		.data_byte (data_s1),
		.sum_next  (sum_nx)
	);

	// checks in priority order
	always_comb begin
		priority if (total < CNT_W'(MIN_HEADER_BYTES)) begin
			status = ST_TOO_SHORT;
		end else if (total < {{(CNT_W-6){1'b0}}, hdr_bytes}) begin
			status = ST_TOO_SHORT;
		end else if (first_nx[7:4] != IP_VERSION) begin
			status = ST_BAD_VERSION;
		end else if (first_nx[3:0] < MIN_IHL) begin
			status = ST_HDR_SHORT;
		end else if (total != {1'b0, length_nx}) begin
			status = ST_LEN_MISMATCH;
		end else if (sum_nx != CSUM_GOOD) begin
			status = ST_BAD_CSUM;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		result        = '0;
		result.status = status;
		// a datagram too short for a fixed header reports no fields
		if (total >= CNT_W'(MIN_HEADER_BYTES)) begin
			result.ihl_words       = first_nx[3:0];
			result.type_of_service = tos_nx;
			result.total_length    = length_nx;
			result.ident           = ident_nx;
			result.dont_fragment   = flags_nx[14];
			result.more_fragments  = flags_nx[13];
			result.frag_offset     = flags_nx[12:0];
			result.time_to_live    = ttl_nx;
			result.protocol        = proto_nx;
			result.source_addr     = src_nx;
			result.dest_addr       = dst_nx;
		end
	end

	// state update, cleared after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			first_q  <= '0;
			tos_q    <= '0;
			length_q <= '0;
			ident_q  <= '0;
			flags_q  <= '0;
			ttl_q    <= '0;
			proto_q  <= '0;
			src_q    <= '0;
			dst_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				count_q  <= '0;
				first_q  <= '0;
				tos_q    <= '0;
				length_q <= '0;
				ident_q  <= '0;
				flags_q  <= '0;
				ttl_q    <= '0;
				proto_q  <= '0;
				src_q    <= '0;
				dst_q    <= '0;
			end else begin
				count_q  <= total;
				first_q  <= first_nx;
				tos_q    <= tos_nx;
				length_q <= length_nx;
				ident_q  <= ident_nx;
				flags_q  <= flags_nx;
				ttl_q    <= ttl_nx;
				proto_q  <= proto_nx;
				src_q    <= src_nx;
				dst_q    <= dst_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= result;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

endmodule

// ----- rtl/iphc_csum.sv -----
`timescale 1ns / 1ps

module iphc_csum import iphc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  csum_ctl_t   ctl,
	input  logic [7:0]  data_byte,
	output logic [15:0] sum_next
);

	logic [7:0]  hold_q;
	logic [15:0] sum_q;
	logic [16:0] raw;
	logic [15:0] folded;

	always_comb begin
		raw    = {1'b0, sum_q} + {1'b0, hold_q, data_byte};
		// end-around carry
		folded = raw[15:0] + {15'd0, raw[16]};
		sum_next = (ctl.take && ctl.odd) ? folded : sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			sum_q  <= '0;
		end else if (ctl.adv) begin
			if (ctl.clr) begin
				hold_q <= '0;
				sum_q  <= '0;
			end else if (ctl.take) begin
				if (ctl.odd) begin
					sum_q <= folded;
				end else begin
					hold_q <= data_byte;
				end
			end
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import iphc_pkg::*;

	// clock, reset and the two channels
	logic clk;
	logic arst_n;

	iphc_byte_if bytes_in ();
	iphc_hdr_if  hdr_out ();

	ipv4_header_parse_check uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (bytes_in),
		.res    (hdr_out)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// directed table: one row per byte word
	// the expected header is typed in only on final bytes whose result
	// is plain to see; all other rows go through the parser model
	// ---------------------------------------------------------------
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       typed;
		hdr_word_t  want;
	} dir_row_t;

	// too short: status only, every field zero
	localparam hdr_word_t WANT_SHORT = '{ST_TOO_SHORT, 4'd0, 8'd0, 16'd0, 16'd0,
		1'b0, 1'b0, 13'd0, 8'd0, 8'd0, 32'd0, 32'd0};
	// smallest clean header, source all ones, destination all zeros
	localparam hdr_word_t WANT_MIN_OK = '{ST_OK, 4'd5, 8'd0, 16'd20, 16'd0,
		1'b0, 1'b0, 13'd0, 8'd0, 8'd0, 32'hffff_ffff, 32'd0};

	// want is ignored on rows with typed low
	localparam dir_row_t DIR_TABLE [24] = '{
		// single byte right after reset
		'{8'h00, 1'b1, 1'b1, WANT_SHORT},
		// three bytes, all-ones first byte: length check wins over version/ihl
		'{8'hff, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'hff, 1'b1, 1'b1, WANT_SHORT},
		// 20 byte header, checksum 0xbaeb makes the sum come out at 0xffff
		'{8'h45, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h14, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'hba, 1'b0, 1'b0, WANT_SHORT},
		'{8'heb, 1'b0, 1'b0, WANT_SHORT},
		'{8'hff, 1'b0, 1'b0, WANT_SHORT},
		'{8'hff, 1'b0, 1'b0, WANT_SHORT},
		'{8'hff, 1'b0, 1'b0, WANT_SHORT},
		'{8'hff, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b0, 1'b0, WANT_SHORT},
		'{8'h00, 1'b1, 1'b1, WANT_MIN_OK}
	};

	// kinds of random datagram
	typedef enum {
		DG_GOOD, DG_BAD_VER, DG_LOW_IHL, DG_BAD_LEN, DG_BAD_CSUM, DG_CUT, DG_TINY
	} dgram_kind_t;

	// ---------------------------------------------------------------
	// parser model state, mirrors the block's counters and captures
	// ---------------------------------------------------------------
	logic [16:0] p_count;
	logic [15:0] p_csum;
	logic [7:0]  p_hold;
	logic [7:0]  p_ver_ihl;
	logic [7:0]  p_tos;
	logic [15:0] p_len;
	logic [15:0] p_ident;
	logic [15:0] p_flags;
	logic [7:0]  p_ttl;
	logic [7:0]  p_proto;
	logic [31:0] p_src;
	logic [31:0] p_dst;

	hdr_word_t   pending_hdrs[$];
	int          mismatch_count;

	// shared between driver, sink and watcher
	bit          calm;        // no idling on either side
	bit          squeeze_req; // ask the sink for one long hold-off
	logic        dir_typed;
	hdr_word_t   dir_want;
	logic [7:0]  dgram_bytes[$];

	task automatic clear_parser();
		p_count   = '0;
		p_csum    = '0;
		p_hold    = '0;
		p_ver_ihl = '0;
		p_tos     = '0;
		p_len     = '0;
		p_ident   = '0;
		p_flags   = '0;
		p_ttl     = '0;
		p_proto   = '0;
		p_src     = '0;
		p_dst     = '0;
	endtask

	// one byte into the model; got high when it closes a datagram
	task automatic parse_byte(input logic [7:0] b, input logic last,
			output logic got, output hdr_word_t r);
		logic [16:0] idx;
		logic [16:0] hdr_len;
		logic [16:0] seen;
		logic [16:0] s;
		status_t     st;

		idx = p_count;
		case (idx)
			17'd0: p_ver_ihl = b;
			17'd1: p_tos = b;
			17'd2, 17'd3: p_len = {p_len[7:0], b};
			17'd4, 17'd5: p_ident = {p_ident[7:0], b};
			17'd6, 17'd7: p_flags = {p_flags[7:0], b};
			17'd8: p_ttl = b;
			17'd9: p_proto = b;
			17'd12, 17'd13, 17'd14, 17'd15: p_src = {p_src[23:0], b};
			17'd16, 17'd17, 17'd18, 17'd19: p_dst = {p_dst[23:0], b};
			default: ;
		endcase
		hdr_len = {11'd0, p_ver_ihl[3:0], 2'b00};

		// header bytes pair up into words, end-around carry
		if (idx < hdr_len) begin
			if (!idx[0]) begin
				p_hold = b;
			end else begin
				s = {1'b0, p_csum} + {1'b0, p_hold, b};
				p_csum = s[16] ? s[15:0] + 16'd1 : s[15:0];
			end
		end

		// count stops at 65536
		seen = (p_count < 17'h10000) ? p_count + 17'd1 : p_count;
		p_count = seen;

		got = last;
		r = hdr_word_t'('0);
		if (last) begin
			if (seen < MIN_HEADER_BYTES)
				st = ST_TOO_SHORT;
			else if (seen < hdr_len)
				st = ST_TOO_SHORT;
			else if (p_ver_ihl[7:4] != IP_VERSION)
				st = ST_BAD_VERSION;
			else if (p_ver_ihl[3:0] < MIN_IHL)
				st = ST_HDR_SHORT;
			else if (seen != {1'b0, p_len})
				st = ST_LEN_MISMATCH;
			else if (p_csum != CSUM_GOOD)
				st = ST_BAD_CSUM;
			else
				st = ST_OK;
			r.status = st;
			if (seen >= MIN_HEADER_BYTES) begin
				r.ihl_words       = p_ver_ihl[3:0];
				r.type_of_service = p_tos;
				r.total_length    = p_len;
				r.ident           = p_ident;
				r.dont_fragment   = p_flags[14];
				r.more_fragments  = p_flags[13];
				r.frag_offset     = p_flags[12:0];
				r.time_to_live    = p_ttl;
				r.protocol        = p_proto;
				r.source_addr     = p_src;
				r.dest_addr       = p_dst;
			end
			clear_parser();
		end
	endtask

	function automatic string hdr_text(hdr_word_t h);
		return $sformatf({"st=%0d ihl=%0d tos=%02h len=%0d id=%04h df=%0d mf=%0d ",
			"off=%0d ttl=%0d proto=%0d src=%08h dst=%08h"},
			h.status, h.ihl_words, h.type_of_service, h.total_length, h.ident,
			h.dont_fragment, h.more_fragments, h.frag_offset, h.time_to_live,
			h.protocol, h.source_addr, h.dest_addr);
	endfunction

	task automatic flag_error(input string why, input hdr_word_t want, input hdr_word_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s", $realtime, why);
			$display("  want %s", hdr_text(want));
			$display("  got  %s", hdr_text(got));
		end
	endtask

	// ---------------------------------------------------------------
	// watcher: both handshakes sampled at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch
		hdr_word_t want;
		logic      got;

		if (arst_n) begin
			// accepted byte word: run the model, queue what it closes
			if (bytes_in.valid && bytes_in.ready) begin
				parse_byte(bytes_in.data.data_byte, bytes_in.data.last_byte, got, want);
				if (got) begin
					if (dir_typed)
						want = dir_want;
					pending_hdrs.push_back(want);
				end
			end
			// accepted header word: compare with the oldest expectation
			if (hdr_out.valid && hdr_out.ready) begin
				if (pending_hdrs.size() == 0) begin
					flag_error("header word with nothing pending", hdr_word_t'('0),
						hdr_out.data);
				end else begin
					want = pending_hdrs.pop_front();
					if (hdr_out.data !== want)
						flag_error("header word mismatch", want, hdr_out.data);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// sink side: random ready, one long hold-off on request
	// ---------------------------------------------------------------
	initial begin : sink_side
		int hold_left;
		bit squeezed;

		hold_left = 0;
		squeezed = 1'b0;
		hdr_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				hdr_out.ready <= 1'b0;
			end else begin
				hdr_out.ready <= calm || ($urandom_range(99) >= 19);
			end
		end
	end

	// ---------------------------------------------------------------
	// source side
	// ---------------------------------------------------------------
	function automatic bit source_rests();
		return !calm && ($urandom_range(99) < 19);
	endfunction

	// entered and left at a falling edge; valid gets one assignment per edge
	task automatic put_byte(input logic [7:0] b, input logic last);
		while (source_rests()) begin
			bytes_in.valid <= 1'b0;
			bytes_in.data  <= byte_word_t'($urandom);
			@(negedge clk);
		end
		bytes_in.valid <= 1'b1;
		bytes_in.data  <= '{b, last};
		@(posedge clk);
		while (!bytes_in.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic dgram_kind_t pick_kind();
		int r;

		r = $urandom_range(99);
		if (r < 50) return DG_GOOD;
		if (r < 58) return DG_BAD_VER;
		if (r < 66) return DG_LOW_IHL;
		if (r < 74) return DG_BAD_LEN;
		if (r < 84) return DG_BAD_CSUM;
		if (r < 92) return DG_CUT;
		return DG_TINY;
	endfunction

	// random content, then, for all but tiny datagrams, the header fixed up to hit the chosen case
	task automatic build_dgram(input dgram_kind_t kind, input int fixed_len);
		int          ver;
		int          ihl;
		int          hdr_len;
		int          len;
		int          i;
		logic [16:0] acc;
		logic [15:0] len_field;

		dgram_bytes.delete();
		ver = 4;
		ihl = ($urandom_range(9) == 0) ? $urandom_range(15, 6) : 5;
		case (kind)
			DG_BAD_VER: begin
				ver = $urandom_range(14);
				if (ver >= 4)
					ver++;
			end
			DG_LOW_IHL: ihl = $urandom_range(4);
			DG_CUT: ihl = $urandom_range(15, 6);
			default: ;
		endcase
		hdr_len = 4 * ihl;
		len = ((hdr_len > 20) ? hdr_len : 20) + $urandom_range(8);
		if (kind == DG_CUT)
			len = $urandom_range(hdr_len - 1, 20);
		if (kind == DG_TINY)
			len = $urandom_range(19, 1);
		if (fixed_len != 0)
			len = fixed_len;
		for (i = 0; i < len; i++)
			dgram_bytes.push_back(8'($urandom));
		if (kind == DG_TINY)
			return;

		len_field = 16'(len);
		if (kind == DG_BAD_LEN)
			len_field ^= 16'($urandom_range(65535, 1));
		dgram_bytes[0] = {4'(ver), 4'(ihl)};
		dgram_bytes[2] = len_field[15:8];
		dgram_bytes[3] = len_field[7:0];
		dgram_bytes[10] = 8'h00;
		dgram_bytes[11] = 8'h00;

		// ones-complement sum over the header words present
		acc = '0;
		for (i = 0; i + 1 < hdr_len && i + 1 < len; i += 2) begin
			acc = acc + {1'b0, dgram_bytes[i], dgram_bytes[i + 1]};
			if (acc[16])
				acc = {1'b0, acc[15:0]} + 17'd1;
		end
		dgram_bytes[10] = ~acc[15:8];
		dgram_bytes[11] = ~acc[7:0];
		if (kind == DG_BAD_CSUM)
			dgram_bytes[11] ^= 8'($urandom_range(255, 1));
	endtask

	task automatic send_dgram();
		int i;

		for (i = 0; i < dgram_bytes.size(); i++)
			put_byte(dgram_bytes[i], i == dgram_bytes.size() - 1);
	endtask

	initial begin : drive
		int n;
		int sent_bytes;

		bytes_in.valid = 1'b0;
		bytes_in.data  = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		squeeze_req = 1'b0;
		dir_typed = 1'b0;
		dir_want = WANT_SHORT;
		mismatch_count = 0;
		clear_parser();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (DIR_TABLE[i]) begin
			dir_typed = DIR_TABLE[i].typed;
			dir_want  = DIR_TABLE[i].want;
			put_byte(DIR_TABLE[i].b, DIR_TABLE[i].last);
		end
		dir_typed = 1'b0;

		// sink holds off while tiny datagrams keep coming: result register
		// fills and final bytes back up into the input
		squeeze_req = 1'b1;
		for (n = 0; n < 30; n++) begin
			build_dgram(DG_TINY, $urandom_range(2, 1));
			send_dgram();
		end

		// random datagrams, each well formed with even odds; a calm stretch in the middle
		sent_bytes = 0;
		for (n = 0; n < 8 || sent_bytes < 220; n++) begin
			calm = (n >= 3 && n < 7);
			build_dgram(pick_kind(), 0);
			sent_bytes += dgram_bytes.size();
			send_dgram();
		end
		calm = 1'b0;

		// a few more at the tail
		for (n = 0; n < 5; n++) begin
			build_dgram(pick_kind(), 0);
			send_dgram();
		end
		bytes_in.valid <= 1'b0;

		// drain, then let the pipe settle
		while (pending_hdrs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
